@@ sv/csvlb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvlb_pkg
// Shared types and constants of the line boundary scanner: configuration
// register indexes, result roles and status codes, and the result group.
// ----------------------------------------------------------------------------
package csvlb_pkg;

  localparam logic [7:0] ESC_CHAR = 8'h5C;

  // An item causes at most this many results.
  localparam int MAX_RES = 4;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int IDX_W   = $clog2(MAX_RES);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SEP_BYTES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUOTE_BYTE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_ON  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LINES  = 3'd4;

  typedef enum logic [1:0] {
    ROLE_DATA     = 2'd0,
    ROLE_LINE_END = 2'd1,
    ROLE_TAIL     = 2'd2,
    ROLE_FINAL    = 2'd3
  } role_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_LIMIT        = 2'd1,
    ST_OPEN_QUOTE   = 2'd2,
    ST_OPEN_LINE    = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] sep_bytes;
    logic [2:0]  sep_len;
    logic [7:0]  quote;
    logic        esc_on;
    logic [31:0] max_lines;
  } cfg_t;

  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    role_t [MAX_RES-1:0]     roles;
    status_t [MAX_RES-1:0]   stats;
    logic [31:0]             lines;
    logic [CNT_W-1:0]        count;
  } grp_t;

endpackage
`default_nettype wire

@@ sv/csvlb_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvlb_in_if
// Input channel of the scanner: one data byte or an end-of-input marker.
// ----------------------------------------------------------------------------
interface csvlb_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source(output valid, kind, data_byte, input ready);
  modport sink(input valid, kind, data_byte, output ready);
endinterface
`default_nettype wire

@@ sv/csvlb_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvlb_out_if
// Result channel of the scanner: one classified byte or a final status.
// ----------------------------------------------------------------------------
interface csvlb_out_if;
  import csvlb_pkg::*;

  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  role_t       role;
  logic [31:0] lines_found;
  status_t     status;
  logic        last;

  modport source(output valid, out_byte, role, lines_found, status, last, input ready);
  modport sink(input valid, out_byte, role, lines_found, status, last, output ready);
endinterface
`default_nettype wire

@@ sv/csvlb_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvlb_core
// Scan state and per-request logic: lookahead window, quote and escape
// flags, line counting and limit, and the group of results for a request.
// ----------------------------------------------------------------------------
module csvlb_core #(
  parameter int SEP_MAX = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire csvlb_pkg::cfg_t cfg,
  input  wire logic            accept,
  input  wire logic            kind,
  input  wire logic [7:0]      data_byte,
  output csvlb_pkg::grp_t      grp
);
  import csvlb_pkg::*;

  localparam int CAP  = (SEP_MAX < 4) ? SEP_MAX : 4;
  localparam int FW   = $clog2(CAP + 1);

  logic [7:0]    win [CAP];
  logic [7:0]    win_next [CAP];
  logic [FW-1:0] fill;
  logic [FW-1:0] fill_next;
  logic          in_quotes;
  logic          in_quotes_next;
  logic          esc_wait;
  logic          esc_wait_next;
  logic [31:0]   line_total;
  logic [31:0]   line_total_next;
  logic          open_line;
  logic          open_line_next;
  logic          limit_hit;
  logic          limit_hit_next;

  // Returns {may_match, escape_waiting, in_quotes} after judging one byte.
  function automatic logic [2:0] judge(input logic [7:0] c, input logic esc,
                                       input logic q, input cfg_t cf);
    logic ok;
    logic e;
    logic qq;
    ok = 1'b0;
    e  = esc;
    qq = q;
    if (esc) begin
      e = 1'b0;
    end else if (cf.esc_on && c == ESC_CHAR) begin
      e = 1'b1;
    end else begin
      if (cf.quote != 8'd0 && c == cf.quote) begin
        qq = ~qq;
      end
      ok = ~qq;
    end
    return {ok, e, qq};
  endfunction

  logic [2:0]    len;
  logic          lim0;
  logic [FW-1:0] fill0;
  logic [FW-1:0] fill1;
  logic [7:0]    w [CAP];
  logic [2:0]    jr;
  logic          match;
  logic [31:0]   tot1;
  logic          lim1;
  status_t       st;

  always_comb begin
    if (cfg.sep_len == 3'd0) begin
      len = 3'd1;
    end else if (cfg.sep_len > 3'(CAP)) begin
      len = 3'(CAP);
    end else begin
      len = cfg.sep_len;
    end
  end

  always_comb begin
    lim0            = limit_hit | (line_total >= cfg.max_lines);
    win_next        = win;
    w               = win;
    fill_next       = fill;
    in_quotes_next  = in_quotes;
    esc_wait_next   = esc_wait;
    line_total_next = line_total;
    open_line_next  = open_line;
    limit_hit_next  = lim0;
    fill0           = '0;
    fill1           = '0;
    jr              = '0;
    match           = 1'b0;
    tot1            = line_total;
    lim1            = lim0;
    st              = ST_OK;
    grp             = '0;
    grp.lines       = line_total;

    if (!kind) begin
      if (!lim0) begin
        fill0 = (3'(fill) >= len) ? '0 : fill;
        for (int j = 0; j < CAP; j++) begin
          if (fill0 == FW'(j)) begin
            w[j] = data_byte;
          end
        end
        fill1          = fill0 + 1'b1;
        open_line_next = 1'b1;
        if (3'(fill1) >= len) begin
          jr             = judge(w[0], esc_wait, in_quotes, cfg);
          esc_wait_next  = jr[1];
          in_quotes_next = jr[0];
          match          = jr[2];
          for (int j = 0; j < CAP; j++) begin
            if (3'(j) < len && w[j] != cfg.sep_bytes[8*j +: 8]) begin
              match = 1'b0;
            end
          end
          if (match) begin
            tot1            = (line_total == '1) ? line_total : line_total + 32'd1;
            lim1            = tot1 >= cfg.max_lines;
            st              = lim1 ? ST_LIMIT : ST_OK;
            line_total_next = tot1;
            limit_hit_next  = lim1;
            grp.lines       = tot1;
            grp.roles[0]    = ROLE_LINE_END;
            grp.stats[0]    = st;
            for (int j = 1; j < CAP; j++) begin
              grp.bytes[j] = w[j];
              grp.roles[j] = ROLE_TAIL;
              grp.stats[j] = st;
            end
            grp.count      = CNT_W'(len);
            fill_next      = '0;
            open_line_next = 1'b0;
          end else begin
            grp.bytes[0] = w[0];
            grp.count    = CNT_W'(1);
            for (int j = 0; j < CAP - 1; j++) begin
              win_next[j] = w[j+1];
            end
            fill_next = fill1 - 1'b1;
          end
        end else begin
          win_next  = w;
          fill_next = fill1;
        end
      end
    end else begin
      if (lim0) begin
        grp.roles[0] = ROLE_FINAL;
        grp.stats[0] = ST_LIMIT;
        grp.count    = CNT_W'(1);
      end else begin
        jr = {1'b0, esc_wait, in_quotes};
        for (int j = 0; j < CAP - 1; j++) begin
          if (3'(j) < 3'(fill)) begin
            jr           = judge(win[j], jr[1], jr[0], cfg);
            grp.bytes[j] = win[j];
          end
        end
        esc_wait_next  = jr[1];
        in_quotes_next = jr[0];
        if (!open_line) begin
          st = ST_OK;
        end else if (jr[0]) begin
          st = ST_OPEN_QUOTE;
        end else begin
          st = ST_OPEN_LINE;
        end
        for (int j = 0; j < MAX_RES; j++) begin
          if (3'(j) == 3'(fill)) begin
            grp.roles[j] = ROLE_FINAL;
            grp.stats[j] = st;
          end
        end
        grp.count = CNT_W'(fill) + CNT_W'(1);
        fill_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      in_quotes  <= 1'b0;
      esc_wait   <= 1'b0;
      line_total <= '0;
      open_line  <= 1'b0;
      limit_hit  <= 1'b0;
    end else if (accept) begin
      fill       <= fill_next;
      in_quotes  <= in_quotes_next;
      esc_wait   <= esc_wait_next;
      line_total <= line_total_next;
      open_line  <= open_line_next;
      limit_hit  <= limit_hit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win <= win_next;
    end
  end

  // The window fill stays below its capacity between requests.
  a_fill_below_cap: assert property (@(posedge clk) disable iff (rst)
    3'(fill) < 3'(CAP))
    else $error("window fill reached terminator capacity");

  // The line count only grows.
  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    accept |=> line_total >= $past(line_total))
    else $error("line count decreased");

  // Once the limit is reached, a data byte causes no result.
  a_limit_silences: assert property (@(posedge clk) disable iff (rst)
    accept && !kind && limit_hit |-> grp.count == '0)
    else $error("data result after line limit");

endmodule
`default_nettype wire

@@ sv/csvlb_outbuf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvlb_outbuf
// Result group register: holds the results of one request and sends them
// one per cycle while ready is high, taking the next group as the last leaves.
// ----------------------------------------------------------------------------
module csvlb_outbuf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire csvlb_pkg::grp_t   grp_in,
  output logic                   in_ready,
  output logic                   valid,
  input  wire logic              ready,
  output logic [7:0]             out_byte,
  output csvlb_pkg::role_t       role,
  output logic [31:0]            lines_found,
  output csvlb_pkg::status_t     status,
  output logic                   last
);
  import csvlb_pkg::*;

  grp_t             grp;
  logic             gvalid;
  logic [IDX_W-1:0] idx;
  logic             take;
  logic             is_last;

  assign is_last     = (CNT_W'(idx) + CNT_W'(1)) == grp.count;
  assign take        = gvalid & ready;
  assign in_ready    = ~gvalid | (take & is_last);
  assign valid       = gvalid;
  assign out_byte    = grp.bytes[idx];
  assign role        = grp.roles[idx];
  assign status      = grp.stats[idx];
  assign lines_found = grp.lines;
  assign last        = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      gvalid <= 1'b0;
      idx    <= '0;
    end else if (load && grp_in.count != '0) begin
      gvalid <= 1'b1;
      idx    <= '0;
    end else if (take) begin
      if (is_last) begin
        gvalid <= 1'b0;
        idx    <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

  // A held group always has a result at the current index.
  a_idx_in_group: assert property (@(posedge clk) disable iff (rst)
    gvalid |-> CNT_W'(idx) < grp.count)
    else $error("result index beyond group");

  // A group is loaded only when the previous one is gone or leaving.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load && gvalid |-> take && is_last)
    else $error("result group overwritten");

  // Taking the last result with nothing new empties the register.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    take && is_last && !load |=> !gvalid)
    else $error("result group not released");

endmodule
`default_nettype wire

@@ sv/csv_line_boundary_scanner.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Latency: the first result of a request is offered the cycle after acceptance.
// Throughput: one request per cycle while each request causes at most one result
// and the results side is ready; the result register sends one result per cycle
// while ready is high and takes no new request until its group (up to 4) has left.
// Reset (synchronous, rst high) clears flags, counters and configuration to their
// defaults; the lookahead window bytes are not cleared.
// ----------------------------------------------------------------------------
// csv_line_boundary_scanner
// Finds record terminators in a byte stream with quoting, escaping and a
// line limit, and reports each byte's role and an end-of-input status.
// ----------------------------------------------------------------------------
module csv_line_boundary_scanner #(
  parameter int SEP_MAX = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [csvlb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [csvlb_pkg::CFG_DATA_W-1:0]    cfg_data,
  csvlb_in_if.sink                                 bytes,
  csvlb_out_if.source                              results
);
  import csvlb_pkg::*;

  cfg_t cfg;
  grp_t grp;
  logic accept;
  logic in_ready;

  assign bytes.ready = in_ready;
  assign accept      = bytes.valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sep_bytes <= 32'd10;
      cfg.sep_len   <= 3'd1;
      cfg.quote     <= 8'd0;
      cfg.esc_on    <= 1'b0;
      cfg.max_lines <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEP_BYTES:  cfg.sep_bytes <= cfg_data;
        REG_SEP_LENGTH: cfg.sep_len   <= cfg_data[2:0];
        REG_QUOTE_BYTE: cfg.quote     <= cfg_data[7:0];
        REG_ESCAPE_ON:  cfg.esc_on    <= cfg_data[0];
        REG_MAX_LINES:  cfg.max_lines <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  csvlb_core #(
    .SEP_MAX(SEP_MAX)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .kind      (bytes.kind),
    .data_byte (bytes.data_byte),
    .grp       (grp)
  );

  csvlb_outbuf u_outbuf (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .grp_in      (grp),
    .in_ready    (in_ready),
    .valid       (results.valid),
    .ready       (results.ready),
    .out_byte    (results.out_byte),
    .role        (results.role),
    .lines_found (results.lines_found),
    .status      (results.status),
    .last        (results.last)
  );

endmodule
`default_nettype wire

@@ bench/csvlb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csvlb_checker
// Watches the configuration port and both channels of the line boundary
// scanner. It keeps its own copy of the registers and of the scanner state,
// works out the classified bytes and final status that each accepted request
// must produce, and compares every accepted result field by field with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module csvlb_checker
  import csvlb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  csvlb_in_if                   bytes_ch,
  csvlb_out_if                  results_ch,
  output int                    errors,
  output int                    marks_due,
  output int                    marks_checked
);

  typedef struct packed {
    logic [7:0]  ch;
    role_t       role;
    logic [31:0] lines;
    status_t     status;
    logic        last;
  } mark_t;

  mark_t       pending_marks[$];
  mark_t       want;
  mark_t       got;
  cfg_t        regs;
  logic [7:0]  win [0:3];
  int          fill;
  bit          in_quote;
  bit          esc_armed;
  bit          line_open;
  bit          limit_seen;
  logic [31:0] line_tally;
  int          fails = 0;
  int          compared = 0;

  function automatic bit take_byte(logic [7:0] c);
    if (esc_armed) begin
      esc_armed = 1'b0;
      return 1'b0;
    end
    if (regs.esc_on && c == ESC_CHAR) begin
      esc_armed = 1'b1;
      return 1'b0;
    end
    if (regs.quote != 8'h00 && c == regs.quote) in_quote = !in_quote;
    return !in_quote;
  endfunction

  function automatic void note(logic [7:0] c, role_t r, status_t s);
    mark_t m;
    m.ch = c;
    m.role = r;
    m.lines = line_tally;
    m.status = s;
    m.last = 1'b0;
    pending_marks.push_back(m);
  endfunction

  function automatic void scan_request(logic kind, logic [7:0] b);
    int      len;
    int      start_size;
    bit      hit;
    status_t st;
    mark_t   m;
    len = regs.sep_len;
    if (len == 0) len = 1;
    if (len > 4) len = 4;
    start_size = pending_marks.size();
    if (line_tally >= regs.max_lines) limit_seen = 1'b1;
    if (!kind) begin
      if (!limit_seen) begin
        if (fill >= len) fill = 0;
        win[fill] = b;
        fill++;
        line_open = 1'b1;
        if (fill >= len) begin
          hit = take_byte(win[0]);
          for (int i = 0; i < len; i++) begin
            if (win[i] != regs.sep_bytes[8*i +: 8]) hit = 1'b0;
          end
          if (hit) begin
            if (line_tally != 32'hFFFF_FFFF) line_tally++;
            if (line_tally >= regs.max_lines) limit_seen = 1'b1;
            st = limit_seen ? ST_LIMIT : ST_OK;
            note(8'h00, ROLE_LINE_END, st);
            for (int i = 1; i < len; i++) note(win[i], ROLE_TAIL, st);
            fill = 0;
            line_open = 1'b0;
          end else begin
            note(win[0], ROLE_DATA, ST_OK);
            for (int i = 1; i < fill; i++) win[i-1] = win[i];
            fill--;
          end
        end
      end
    end else if (limit_seen) begin
      note(8'h00, ROLE_FINAL, ST_LIMIT);
    end else begin
      for (int i = 0; i < fill; i++) begin
        void'(take_byte(win[i]));
        note(win[i], ROLE_DATA, ST_OK);
      end
      fill = 0;
      st = !line_open ? ST_OK : (in_quote ? ST_OPEN_QUOTE : ST_OPEN_LINE);
      note(8'h00, ROLE_FINAL, st);
    end
    if (pending_marks.size() > start_size) begin
      m = pending_marks.pop_back();
      m.last = 1'b1;
      pending_marks.push_back(m);
    end
  endfunction

  function automatic void check_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs = '{sep_bytes: 32'd10, sep_len: 3'd1, quote: 8'h00, esc_on: 1'b0,
               max_lines: 32'hFFFF_FFFF};
      fill = 0;
      in_quote = 1'b0;
      esc_armed = 1'b0;
      line_open = 1'b0;
      limit_seen = 1'b0;
      line_tally = 32'd0;
      pending_marks.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SEP_BYTES:  regs.sep_bytes = cfg_data;
          REG_SEP_LENGTH: regs.sep_len = cfg_data[2:0];
          REG_QUOTE_BYTE: regs.quote = cfg_data[7:0];
          REG_ESCAPE_ON:  regs.esc_on = cfg_data[0];
          REG_MAX_LINES:  regs.max_lines = cfg_data;
          default: ;
        endcase
      end
      if (bytes_ch.valid && bytes_ch.ready) scan_request(bytes_ch.kind, bytes_ch.data_byte);
      if (results_ch.valid && results_ch.ready) begin
        got.ch = results_ch.out_byte;
        got.role = results_ch.role;
        got.lines = results_ch.lines_found;
        got.status = results_ch.status;
        got.last = results_ch.last;
        if (pending_marks.size() == 0) begin
          fails++;
          $display("%0t: result with nothing expected, actual byte %0h role %0d status %0d",
                   $time, got.ch, got.role, got.status);
        end else begin
          want = pending_marks.pop_front();
          compared++;
          check_field("out_byte", want.ch, got.ch);
          check_field("role", want.role, got.role);
          check_field("lines_found", want.lines, got.lines);
          check_field("status", want.status, got.status);
          check_field("last", want.last, got.last);
        end
      end
    end
    errors <= fails;
    marks_due <= pending_marks.size();
    marks_checked <= compared;
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the line boundary scanner with directed byte streams for quoting,
// escaping, multi-byte terminators, length changes and the line limit, then
// with random streams of lines under random and extreme register settings,
// with idle gaps on both channels and one long result stall. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import csvlb_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 150;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int          cycle_count = 0;
  int          sent = 0;
  int          ends_sent = 0;
  int          settings_used = 0;
  int          scan_errors;
  int          marks_due;
  int          marks_checked;
  logic [31:0] seen_lines = 32'd0;
  cfg_t        cur;

  csvlb_in_if  bytes_ch();
  csvlb_out_if results_ch();

  csv_line_boundary_scanner #(.SEP_MAX(4)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bytes     (bytes_ch),
    .results   (results_ch)
  );

  csvlb_checker scan_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .bytes_ch      (bytes_ch),
    .results_ch    (results_ch),
    .errors        (scan_errors),
    .marks_due     (marks_due),
    .marks_checked (marks_checked)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
      hold_left <= 0;
      holds_served <= 0;
    end else if (hold_left != 0) begin
      results_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      results_ch.ready <= 1'b0;
      holds_served <= holds_served + 1;
      hold_left <= LONG_HOLD;
    end else begin
      results_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (results_ch.valid && results_ch.ready) seen_lines <= results_ch.lines_found;
  end

  task automatic set_idle(input int tx, input int rx);
    tx_idle_pct = tx;
    rx_idle_pct <= rx;
  endtask

  // The ready seen between edges is the one that the next edge uses.
  task automatic send_req(input logic kind, input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      bytes_ch.valid <= 1'b0;
      bytes_ch.kind <= 1'($urandom);
      bytes_ch.data_byte <= 8'($urandom);
      @(posedge clk);
    end
    bytes_ch.valid <= 1'b1;
    bytes_ch.kind <= kind;
    bytes_ch.data_byte <= b;
    @(negedge clk);
    while (!bytes_ch.ready) @(negedge clk);
    @(posedge clk);
    sent++;
    if (kind) ends_sent++;
  endtask

  // Items that end inside the window cause no result, hence the extra cycles.
  task automatic settle();
    bytes_ch.valid <= 1'b0;
    do @(posedge clk); while (marks_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input cfg_t s);
    write_reg(REG_SEP_BYTES, s.sep_bytes);
    write_reg(REG_SEP_LENGTH, 32'(s.sep_len));
    write_reg(REG_QUOTE_BYTE, 32'(s.quote));
    write_reg(REG_ESCAPE_ON, 32'(s.esc_on));
    write_reg(REG_MAX_LINES, s.max_lines);
    cfg_we <= 1'b0;
    cur = s;
    settings_used++;
  endtask

  function automatic cfg_t random_setting();
    cfg_t s;
    s.sep_len = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4, 1));
    s.sep_bytes = $urandom;
    s.quote = ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom);
    s.esc_on = 1'($urandom_range(1));
    s.max_lines = ($urandom_range(1) == 0) ? 32'hFFFF_FFFF : {1'b1, 31'($urandom)};
    return s;
  endfunction

  function automatic logic [7:0] content_byte();
    logic [7:0] pick;
    int         r;
    int         j;
    r = $urandom_range(99);
    j = $urandom_range(3);
    if (r < 40) pick = 8'($urandom);
    else if (r < 60) pick = cur.quote;
    else if (r < 75) pick = ESC_CHAR;
    else pick = cur.sep_bytes[8*j +: 8];
    return pick;
  endfunction

  // Mostly whole lines with random content and the terminator, some cut
  // short, some lone noise bytes, and an end-of-input request to close.
  task automatic run_phase(input cfg_t s, input int budget);
    int n;
    int k;
    int len;
    int cut;
    apply_setting(s);
    n = 0;
    len = (s.sep_len == 0) ? 1 : ((s.sep_len > 4) ? 4 : int'(s.sep_len));
    while (n < budget) begin
      if ($urandom_range(9) < 7) begin
        k = $urandom_range(4);
        repeat (k) begin
          send_req(1'b0, content_byte());
          n++;
        end
        cut = ($urandom_range(7) == 0) ? $urandom_range(len - 1) : len;
        for (int j = 0; j < cut; j++) begin
          send_req(1'b0, s.sep_bytes[8*j +: 8]);
          n++;
        end
      end else begin
        send_req(1'b0, 8'($urandom));
        n++;
      end
    end
    send_req(1'b1, 8'($urandom));
    settle();
  endtask

  initial begin
    bytes_ch.valid = 1'b0;
    bytes_ch.kind = 1'b0;
    bytes_ch.data_byte = 8'h00;
    results_ch.ready = 1'b0;
    set_idle(17, 77);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_req(1'b0, 8'h00);
    send_req(1'b0, 8'h0A);
    send_req(1'b1, 8'h00);
    send_req(1'b0, 8'hFF);
    send_req(1'b1, 8'hA5);
    send_req(1'b1, 8'h5A);
    settle();

    apply_setting('{sep_bytes: 32'h0000_0A0D, sep_len: 3'd2, quote: 8'h22, esc_on: 1'b1,
                    max_lines: 32'hFFFF_FFFF});
    send_req(1'b0, 8'h22);
    send_req(1'b0, 8'h0D);
    send_req(1'b0, 8'h0A);
    send_req(1'b0, 8'h22);
    send_req(1'b0, ESC_CHAR);
    send_req(1'b0, 8'h0D);
    send_req(1'b0, 8'h0A);
    send_req(1'b0, 8'h0D);
    send_req(1'b0, 8'h0A);
    send_req(1'b0, 8'h22);
    send_req(1'b0, 8'h71);
    send_req(1'b1, 8'h00);
    settle();

    apply_setting('{sep_bytes: 32'h6463_6261, sep_len: 3'd7, quote: 8'h00, esc_on: 1'b0,
                    max_lines: 32'hFFFF_FFFF});
    send_req(1'b0, 8'h61);
    send_req(1'b0, 8'h62);
    send_req(1'b0, 8'h63);
    send_req(1'b0, 8'h64);
    send_req(1'b0, 8'h61);
    send_req(1'b0, 8'h62);
    send_req(1'b0, 8'h63);
    settle();

    // The window still holds three bytes when the terminator shrinks.
    apply_setting('{sep_bytes: 32'h0000_000A, sep_len: 3'd1, quote: 8'h22, esc_on: 1'b0,
                    max_lines: 32'hFFFF_FFFF});
    send_req(1'b0, 8'h41);
    send_req(1'b1, 8'h00);
    settle();

    run_phase(random_setting(), 11);
    run_phase('{sep_bytes: 32'hFFFF_FFFF, sep_len: 3'd4, quote: 8'hFF, esc_on: 1'b1,
                max_lines: 32'hFFFF_FFFF}, 11);
    set_idle(77, 17);
    run_phase(random_setting(), 11);
    run_phase(random_setting(), 11);
    set_idle(0, 0);
    hold_requests <= hold_requests + 1;
    run_phase(random_setting(), 11);
    run_phase(random_setting(), 11);

    apply_setting('{sep_bytes: 32'h0000_0041, sep_len: 3'd0, quote: 8'h00, esc_on: 1'b0,
                    max_lines: seen_lines + 32'd2});
    send_req(1'b0, 8'h41);
    send_req(1'b0, 8'h42);
    send_req(1'b0, 8'h41);
    send_req(1'b0, 8'h41);
    send_req(1'b1, 8'h00);
    settle();

    apply_setting('{sep_bytes: 32'h0000_0000, sep_len: 3'd7, quote: 8'hFF, esc_on: 1'b1,
                    max_lines: 32'd0});
    send_req(1'b0, 8'h00);
    send_req(1'b0, 8'hFF);
    send_req(1'b1, 8'hFF);
    settle();

    $display("Run covered %0d requests, %0d of them end of input, under %0d settings.",
             sent, ends_sent, settings_used);
    $display("%0d results compared with their predictions.", marks_checked);
    if (scan_errors == 0 && marks_due == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
